FILE: sv/assert_macros.svh
// assertion macros shared by the rtl of the prewitt x window filter
// no dependencies; include by bare file name inside a module body
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, idle while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// concurrent check that also runs through reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/pxw_pkg.sv
// shared constants and types for the prewitt x window filter
// no dependencies
`timescale 1ns / 1ps

package pxw_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
  localparam int PIXEL_BITS = 8;
  localparam int WIN        = 3;
  localparam int SUM_BITS   = PIXEL_BITS + 2;
  localparam int EDGE_BITS  = 11;
  localparam int WIDTH_BITS = 11;
  localparam int HEIGHT_BITS = 12;
  localparam int CFG_BITS   = 12;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(6);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(6);
  localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN    = WIDTH_BITS'(WIN);
  localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX    = WIDTH_BITS'(MAX_WIDTH);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN   = HEIGHT_BITS'(WIN);

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [SUM_BITS-1:0]   sum_t;

  // per word status carried from the scan stage into the gradient stage
  typedef struct packed {
    logic has_result;
    logic last;
  } tag_t;

endpackage

FILE: sv/prewitt_x_window_filter.sv
// Prewitt x gradient over a 3x3 window of a raster pixel stream. One pixel word is
// taken per clock while pixel_stall is low; words pass the scan stage, then the output
// register. The line stores take one read (at acceptance) and one write back (as the
// word leaves the scan stage) per pixel. Results appear only where the window lies
// inside the frame, row and column from 2 on; last_of_frame marks the final one. Width
// is clamped to 3..1024, height to at least 3. Line stores are not cleared at reset.
// depends on pxw_pkg, pxw_line_store, pxw_gradient and assert_macros.svh
`timescale 1ns / 1ps

module prewitt_x_window_filter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [0:0]                           cfg_index,
  input  logic [pxw_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic                                 pixel_valid,
  output logic                                 pixel_stall,
  input  logic [pxw_pkg::PIXEL_BITS-1:0]       pixel,
  output logic                                 edge_valid,
  input  logic                                 edge_stall,
  output logic signed [pxw_pkg::EDGE_BITS-1:0] edge_value,
  output logic                                 last_of_frame
);
  import pxw_pkg::*;
  `include "assert_macros.svh"

  logic [WIDTH_BITS-1:0]  width_in_use;
  logic [HEIGHT_BITS-1:0] height_in_use;
  logic [WIDTH_BITS-1:0]  width_eff;
  logic [HEIGHT_BITS-1:0] height_eff;

  addr_t                  col;
  addr_t                  col_next;
  logic [HEIGHT_BITS-1:0] row;
  logic [HEIGHT_BITS-1:0] row_next;
  logic                   end_row;
  logic                   end_frame;
  logic                   accept;

  logic   s1_valid;
  addr_t  s1_addr;
  pixel_t s1_pixel;
  tag_t   s1_tag;
  logic   s1_adv;
  logic   out_free;

  pixel_t rd_upper;
  pixel_t rd_middle;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= WIDTH_RESET;
      height_in_use <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  width_in_use  <= cfg_data[WIDTH_BITS-1:0];
        REG_HEIGHT: height_in_use <= cfg_data[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign width_eff  = (width_in_use < WIDTH_MIN) ? WIDTH_MIN :
                      (width_in_use > WIDTH_MAX) ? WIDTH_MAX : width_in_use;
  assign height_eff = (height_in_use < HEIGHT_MIN) ? HEIGHT_MIN : height_in_use;

  // raster position
  assign accept    = pixel_valid && !pixel_stall;
  assign end_row   = ({1'b0, col} + WIDTH_BITS'(1)) >= width_eff;
  assign end_frame = end_row && (({1'b0, row} + (HEIGHT_BITS + 1)'(1)) >= {1'b0, height_eff});

  always_comb begin
    col_next = col + ADDR_BITS'(1);
    row_next = row;
    if (end_row) begin
      col_next = '0;
      row_next = end_frame ? '0 : row + HEIGHT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // scan stage, holds the accepted pixel while the line store read data is registered
  assign s1_adv      = s1_valid && out_free;
  assign pixel_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr           <= col;
      s1_pixel          <= pixel[PIXEL_BITS-1:0];
      s1_tag.has_result <= (row >= HEIGHT_BITS'(WIN - 1)) && (col >= ADDR_BITS'(WIN - 1));
      s1_tag.last       <= end_frame;
    end
  end

  pxw_line_store u_line_store (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (col),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle),
    .wr_en     (s1_adv),
    .wr_addr   (s1_addr),
    .wr_upper  (rd_middle),
    .wr_middle (s1_pixel)
  );

  pxw_gradient u_gradient (
    .clk           (clk),
    .rst           (rst),
    .adv           (s1_adv),
    .tag           (s1_tag),
    .top           (rd_upper),
    .mid           (rd_middle),
    .pix           (s1_pixel),
    .out_free      (out_free),
    .edge_valid    (edge_valid),
    .edge_stall    (edge_stall),
    .edge_value    (edge_value),
    .last_of_frame (last_of_frame)
  );

  `ASSERT_CLK(a_no_rw_collision, (accept && s1_adv) |-> (col != s1_addr), "line store read meets write")
  `ASSERT_CLK(a_stall_only_full, pixel_stall |-> s1_valid, "input stalled with scan stage empty")
  `ASSERT_CLK(a_frame_wrap, (accept && end_frame) |=> (col == '0 && row == '0), "position did not wrap")
  `ASSERT_ALWAYS(a_reset_clears, rst |=> (!s1_valid && !edge_valid), "pipeline busy after reset")

endmodule

FILE: sv/pxw_line_store.sv
// upper and middle line stores, one read and one write port each
// depends on pxw_pkg
`timescale 1ns / 1ps

module pxw_line_store (
  input  logic           clk,
  input  logic           rd_en,
  input  pxw_pkg::addr_t rd_addr,
  output pxw_pkg::pixel_t rd_upper,
  output pxw_pkg::pixel_t rd_middle,
  input  logic           wr_en,
  input  pxw_pkg::addr_t wr_addr,
  input  pxw_pkg::pixel_t wr_upper,
  input  pxw_pkg::pixel_t wr_middle
);
  import pxw_pkg::*;

  pixel_t upper_mem  [MAX_WIDTH];
  pixel_t middle_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper  <= upper_mem[rd_addr];
      rd_middle <= middle_mem[rd_addr];
    end
  end

endmodule

FILE: sv/pxw_gradient.sv
// column sums of the window, gradient and output register
// depends on pxw_pkg and assert_macros.svh
`timescale 1ns / 1ps

module pxw_gradient (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  pxw_pkg::tag_t              tag,
  input  pxw_pkg::pixel_t            top,
  input  pxw_pkg::pixel_t            mid,
  input  pxw_pkg::pixel_t            pix,
  output logic                       out_free,
  output logic                       edge_valid,
  input  logic                       edge_stall,
  output logic signed [pxw_pkg::EDGE_BITS-1:0] edge_value,
  output logic                       last_of_frame
);
  import pxw_pkg::*;
  `include "assert_macros.svh"

  sum_t col1_sum;
  sum_t col2_sum;
  sum_t right_sum;
  logic [EDGE_BITS-1:0] diff;

  assign right_sum = SUM_BITS'(top) + SUM_BITS'(mid) + SUM_BITS'(pix);
  assign diff = EDGE_BITS'(col1_sum) - EDGE_BITS'(right_sum);
  assign out_free = !edge_valid || !edge_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      col1_sum <= '0;
      col2_sum <= '0;
    end else if (adv) begin
      col1_sum <= col2_sum;
      col2_sum <= right_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_valid <= 1'b0;
    end else if (adv && tag.has_result) begin
      edge_valid <= 1'b1;
    end else if (!edge_stall) begin
      edge_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tag.has_result) begin
      edge_value    <= signed'(diff);
      last_of_frame <= tag.last;
    end
  end

  `ASSERT_CLK(a_no_overwrite, adv |-> out_free, "word advanced into a held output")
  `ASSERT_CLK(a_result_loads, (adv && tag.has_result) |=> edge_valid, "result word lost")

endmodule
